[rtl/lcn_pkg.sv]
// lcn_pkg: types and fixed constants of the lightmap combine/normalise block.
// Used by lcn_div and lightmap_combine_normalize. No dependencies.
package lcn_pkg;

    localparam int SAMPLE_W  = 8;
    localparam int GAIN_W    = 16;
    localparam int PROD_W    = SAMPLE_W + GAIN_W;
    localparam int SUM_W     = 26;
    localparam int FRAC_W    = 8;
    localparam int CHAN_W    = SUM_W - FRAC_W;
    localparam int DIVD_W    = CHAN_W + 8;
    localparam int QUOT_W    = 8;
    localparam int CFG_W     = 48;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_GAINS = 4;

    localparam logic [CFG_W-1:0]  GAIN_ONE = 48'h0100_0100_0100;
    localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};
    localparam logic [QUOT_W-1:0] BYTE_MAX = 8'hFF;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_STYLES  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_BRIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STYLE0_GAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STYLE1_GAIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STYLE2_GAIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STYLE3_GAIN = 3'd5;

    typedef struct packed {
        logic [7:0] sample_red;
        logic [7:0] sample_green;
        logic [7:0] sample_blue;
        logic [1:0] layer_index;
    } sample_t;

    typedef struct packed {
        logic [7:0] out_blue;
        logic [7:0] out_green;
        logic [7:0] out_red;
        logic [7:0] out_alpha;
    } texel_t;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [CHAN_W-1:0] divisor;
    } div_req_t;

endpackage

[rtl/lcn_div.sv]
// lcn_div: restoring divider, one quotient bit per cycle, 8-bit quotient.
// Caller guarantees dividend < divisor * 256. Depends on lcn_pkg.
module lcn_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lcn_pkg::div_req_t             req,
    output logic                          done,
    output logic [lcn_pkg::QUOT_W-1:0]    quotient
);

    localparam int DSH_W = lcn_pkg::CHAN_W + lcn_pkg::QUOT_W - 1;

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [2:0]                    cnt_reg, cnt_next;
    logic [lcn_pkg::DIVD_W-1:0]    rem_reg, rem_next;
    logic [DSH_W-1:0]              dsh_reg, dsh_next;
    logic [lcn_pkg::QUOT_W-1:0]    q_reg, q_next;
    logic                          fits;

    assign fits = {1'b0, dsh_reg} <= rem_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = 3'd7;
            rem_next  = req.dividend;
            dsh_next  = {req.divisor, 7'b0};
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            if (fits)
                rem_next = rem_reg - {1'b0, dsh_reg};
            q_next   = {q_reg[lcn_pkg::QUOT_W-2:0], fits};
            dsh_next = dsh_reg >> 1;
            cnt_next = cnt_reg - 3'd1;
            if (cnt_reg == 3'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

[rtl/lightmap_combine_normalize.sv]
// lightmap_combine_normalize: sums style layers of a texel through one shared
// 8x16 multiplier, then rescales overbright texels with lcn_div. Uses lcn_pkg.
// A layer is accepted in idle, then multiplied and accumulated per channel; a
// closing layer then passes close and, when overbright, three divisions before
// emit. Full-bright items go straight to emit. One item at a time; the input
// stalls until the block is back in idle, also while emit waits on out_stall.
// Reset (async, active low) clears sums and control; config regs get defaults.
module lightmap_combine_normalize #(
    parameter int MAX_STYLES = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  lcn_pkg::sample_t                  in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output lcn_pkg::texel_t                   out_data,
    input  logic                              cfg_write,
    input  logic [lcn_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lcn_pkg::CFG_W-1:0]         cfg_data
);

    localparam int         LIMIT   = (MAX_STYLES < 4) ? MAX_STYLES : 4;
    localparam logic [2:0] LIMIT_V = 3'(LIMIT);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MAC   = 3'd1;
    localparam logic [2:0] ST_CLOSE = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_WAIT  = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;

    logic [2:0]                       state_reg, state_next;
    logic [1:0]                       ch_reg, ch_next;
    lcn_pkg::sample_t                 item_reg, item_next;
    logic [lcn_pkg::SUM_W-1:0]        sum_reg [3];
    logic [lcn_pkg::SUM_W-1:0]        sum_next [3];
    logic [lcn_pkg::CHAN_W-1:0]       chan_reg [3];
    logic [lcn_pkg::CHAN_W-1:0]       chan_next [3];
    logic [lcn_pkg::CHAN_W-1:0]       max_reg, max_next;
    logic [7:0]                       res_reg [3];
    logic [7:0]                       res_next [3];
    logic                             out_valid_reg, out_valid_next;
    lcn_pkg::texel_t                  out_data_reg, out_data_next;

    logic [2:0]                       num_styles_reg;
    logic                             full_bright_reg;
    logic [lcn_pkg::CFG_W-1:0]        gain_reg [lcn_pkg::NUM_GAINS];

    logic [7:0]                       sample_sel;
    logic [lcn_pkg::GAIN_W-1:0]       gain_sel;
    logic [lcn_pkg::CFG_W-1:0]        gain_word;
    logic [lcn_pkg::PROD_W-1:0]       prod;
    logic [lcn_pkg::SUM_W:0]          acc_wide;
    logic [lcn_pkg::SUM_W-1:0]        acc_sat;
    logic [2:0]                       layer_count;
    logic                             closes;
    logic [lcn_pkg::CHAN_W-1:0]       t_r, t_g, t_b, t_rg, t_max;
    logic                             accept;
    lcn_pkg::div_req_t                div_req;
    logic                             div_done;
    logic [lcn_pkg::QUOT_W-1:0]       div_q;

    lcn_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_q)
    );

    assign accept   = in_valid && !in_stall;
    assign in_stall = state_reg != ST_IDLE;

    always_comb
    begin
        layer_count = (num_styles_reg == 3'd0) ? 3'd1 : num_styles_reg;
        if (layer_count > LIMIT_V)
            layer_count = LIMIT_V;
    end

    assign closes = ({1'b0, item_reg.layer_index} + 3'd1) >= layer_count;

    // shared multiply-accumulate, one channel a cycle
    assign gain_word = gain_reg[item_reg.layer_index];
    always_comb
    begin
        case (ch_reg)
            2'd0:
            begin
                sample_sel = item_reg.sample_red;
                gain_sel   = gain_word[47:32];
            end
            2'd1:
            begin
                sample_sel = item_reg.sample_green;
                gain_sel   = gain_word[31:16];
            end
            default:
            begin
                sample_sel = item_reg.sample_blue;
                gain_sel   = gain_word[15:0];
            end
        endcase
    end

    assign prod     = {16'b0, sample_sel} * {8'b0, gain_sel};
    assign acc_wide = {1'b0, sum_reg[ch_reg]} + {3'b0, prod};
    assign acc_sat  = acc_wide[lcn_pkg::SUM_W] ? lcn_pkg::SUM_MAX
                                               : acc_wide[lcn_pkg::SUM_W-1:0];

    assign t_r   = sum_reg[0][lcn_pkg::SUM_W-1:lcn_pkg::FRAC_W];
    assign t_g   = sum_reg[1][lcn_pkg::SUM_W-1:lcn_pkg::FRAC_W];
    assign t_b   = sum_reg[2][lcn_pkg::SUM_W-1:lcn_pkg::FRAC_W];
    assign t_rg  = (t_r > t_g) ? t_r : t_g;
    assign t_max = (t_b > t_rg) ? t_b : t_rg;

    always_comb
    begin
        state_next     = state_reg;
        ch_next        = ch_reg;
        item_next      = item_reg;
        max_next       = max_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;
        for (int i = 0; i < 3; i++)
        begin
            sum_next[i]  = sum_reg[i];
            chan_next[i] = chan_reg[i];
            res_next[i]  = res_reg[i];
        end
        div_req.start    = 1'b0;
        div_req.dividend = {chan_reg[ch_reg], 8'b0} - {8'b0, chan_reg[ch_reg]};
        div_req.divisor  = max_reg;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    item_next = in_data;
                    ch_next   = 2'd0;
                    if (full_bright_reg)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            sum_next[i] = '0;
                            res_next[i] = lcn_pkg::BYTE_MAX;
                        end
                        state_next = ST_EMIT;
                    end
                    else
                        state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                sum_next[ch_reg] = acc_sat;
                if (ch_reg == 2'd2)
                    state_next = closes ? ST_CLOSE : ST_IDLE;
                else
                    ch_next = ch_reg + 2'd1;
            end
            ST_CLOSE:
            begin
                chan_next[0] = t_r;
                chan_next[1] = t_g;
                chan_next[2] = t_b;
                max_next     = t_max;
                for (int i = 0; i < 3; i++)
                    sum_next[i] = '0;
                ch_next = 2'd0;
                if (t_max > lcn_pkg::CHAN_W'(lcn_pkg::BYTE_MAX))
                    state_next = ST_DIV;
                else
                begin
                    res_next[0] = t_r[7:0];
                    res_next[1] = t_g[7:0];
                    res_next[2] = t_b[7:0];
                    state_next  = ST_EMIT;
                end
            end
            ST_DIV:
            begin
                div_req.start = 1'b1;
                state_next    = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (div_done)
                begin
                    res_next[ch_reg] = div_q;
                    if (ch_reg == 2'd2)
                        state_next = ST_EMIT;
                    else
                    begin
                        ch_next    = ch_reg + 2'd1;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_data_next.out_blue  = res_reg[2];
                    out_data_next.out_green = res_reg[1];
                    out_data_next.out_red   = res_reg[0];
                    out_data_next.out_alpha = lcn_pkg::BYTE_MAX;
                    out_valid_next          = 1'b1;
                    state_next              = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ch_reg        <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
                sum_reg[i] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            ch_reg        <= ch_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < 3; i++)
                sum_reg[i] <= sum_next[i];
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        max_reg      <= max_next;
        out_data_reg <= out_data_next;
        for (int i = 0; i < 3; i++)
        begin
            chan_reg[i] <= chan_next[i];
            res_reg[i]  <= res_next[i];
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_styles_reg  <= 3'd1;
            full_bright_reg <= 1'b0;
            for (int i = 0; i < lcn_pkg::NUM_GAINS; i++)
                gain_reg[i] <= lcn_pkg::GAIN_ONE;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                lcn_pkg::REG_NUM_STYLES:  num_styles_reg  <= cfg_data[2:0];
                lcn_pkg::REG_FULL_BRIGHT: full_bright_reg <= cfg_data[0];
                lcn_pkg::REG_STYLE0_GAIN: gain_reg[0]     <= cfg_data;
                lcn_pkg::REG_STYLE1_GAIN: gain_reg[1]     <= cfg_data;
                lcn_pkg::REG_STYLE2_GAIN: gain_reg[2]     <= cfg_data;
                lcn_pkg::REG_STYLE3_GAIN: gain_reg[3]     <= cfg_data;
                default:                  ;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTHESIS
    a_alpha_white: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_data_reg.out_alpha == lcn_pkg::BYTE_MAX)
        else $error("texel alpha not 255");

    a_fb_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && full_bright_reg) |=> state_reg == ST_EMIT)
        else $error("full-bright item did not go straight to emit");

    a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_WAIT)
        else $error("divider finished outside its wait state");

    a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLOSE |=> sum_reg[0] == '0 && sum_reg[1] == '0 && sum_reg[2] == '0)
        else $error("sums not cleared after texel close");
`endif

endmodule
